[hdl/acia_pkg.sv]
// ----------------------------------------------------------------------------
// acia register model package
// types, codes and decode helpers shared by the serial register block and its checker
// ----------------------------------------------------------------------------
package acia_pkg;

	localparam int RX_DEPTH = 8;
	localparam int PTR_W    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int CNT_W    = $clog2(RX_DEPTH + 1);

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [3:0] {
		OP_CMD_RD  = 4'd0,
		OP_CMD_WR  = 4'd1,
		OP_CTL_RD  = 4'd2,
		OP_CTL_WR  = 4'd3,
		OP_STATUS  = 4'd4,
		OP_RX_RD   = 4'd5,
		OP_TX      = 4'd6,
		OP_LINE    = 4'd7,
		OP_TICK    = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		PAR_NONE  = 3'd0,
		PAR_ODD   = 3'd1,
		PAR_EVEN  = 3'd2,
		PAR_MARK  = 3'd3,
		PAR_SPACE = 3'd4
	} parity_t;

	typedef enum logic [1:0] {
		STOP_ONE      = 2'd0,
		STOP_ONE_HALF = 2'd1,
		STOP_TWO      = 2'd2
	} stop_t;

	localparam logic [7:0] CMD_RESET   = 8'h00;
	localparam logic [7:0] CTL_RESET   = 8'h1F;
	localparam logic [7:0] CMD_PAR_EN  = 8'h20;
	localparam logic [7:0] CMD_RTS     = 8'h0C;
	localparam logic [7:0] CMD_TX_IRQ  = 8'h04;
	localparam logic [7:0] CMD_DTR     = 8'h01;
	localparam logic [7:0] CMD_RX_IRQD = 8'h02;
	localparam logic [7:0] CTL_STOP2   = 8'h80;
	localparam logic [7:0] ST_BASE     = 8'h10;
	localparam logic [7:0] ST_RX_FULL  = 8'h08;
	localparam logic [7:0] ST_NO_DCD   = 8'h20;
	localparam logic [7:0] ST_NO_DSR   = 8'h40;
	localparam logic [7:0] ST_IRQ      = 8'h80;

	localparam logic [14:0] RATE_RESET = 15'd19200;
	localparam logic [3:0]  BITS_RESET = 4'd8;

	typedef struct packed {
		logic       rx_dropped;
		logic       irq_assert;
		logic       dtr_enable;
		logic       rts_enable;
		stop_t      stop_bits;
		parity_t    parity_mode;
		logic [3:0] data_bits;
		logic [14:0] baud_rate;
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic [7:0] read_data;
	} result_t;

	function automatic logic [14:0] decode_rate(input logic [3:0] code);
		logic [14:0] r;
		begin
			case (code)
				4'd6:          r = 15'd300;
				4'd7:          r = 15'd600;
				4'd8:          r = 15'd1200;
				4'd9, 4'd10:   r = 15'd2400;
				4'd11, 4'd12:  r = 15'd4800;
				4'd13, 4'd14:  r = 15'd9600;
				4'd15:         r = 15'd19200;
				default:       r = 15'd110;
			endcase
			return r;
		end
	endfunction

endpackage

[hdl/acia_serial_register_model_top.sv]
// ----------------------------------------------------------------------------
// acia serial register model, top level
// 6551-style command, control, status and receive buffer registers
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tuser opcode, tdata data_in / carrier / dsr
//  m_axis   | out       | tdata one result per access
//
// one access per cycle sustained while results are taken; an access passes the input
// register, which feeds decode and state update, and then the result register, which
// holds the outcome until its transfer
// a stalled result holds the input stage; the input register still takes a
// new access while the result register drains
// arst_n sets all control state to its reset values and clears the receive buffer count
module acia_serial_register_model_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [acia_pkg::IN_DATA_W-1:0]  s_axis_tdata, // data_in, carrier_detect, data_set_ready
	input  logic [3:0]                    s_axis_tuser, // opcode
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [acia_pkg::OUT_DATA_W-1:0] m_axis_tdata  // read_data, tx_valid, tx_byte,
	                                                      // baud_rate, data_bits, parity_mode,
	                                                      // stop_bits, rts_enable, dtr_enable,
	                                                      // irq_assert, rx_dropped
);
	import acia_pkg::*;

	// input stage
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] data_s1;
	logic       cd_s1;
	logic       dsr_s1;

	// result stage
	logic    out_valid_q;
	result_t res_q;

	// register state
	logic [7:0]  command_q;
	logic [7:0]  control_q;
	parity_t     parity_q;
	logic [3:0]  char_bits_q;
	stop_t       stop_q;
	logic [14:0] rate_q;
	logic        rts_q;
	logic        dtr_q;
	logic        rx_flag_q;
	logic        tx_flag_q;
	logic [7:0]  rx_fifo_q [RX_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] rx_count_q;

	// next state
	logic [7:0]  command_d;
	logic [7:0]  control_d;
	parity_t     parity_d;
	logic [3:0]  char_bits_d;
	stop_t       stop_d;
	logic [14:0] rate_d;
	logic        rts_d;
	logic        dtr_d;
	logic        rx_flag_d;
	logic        tx_flag_d;
	logic [PTR_W-1:0] head_d;
	logic [CNT_W-1:0] rx_count_d;
	logic        wr_en;
	logic [PTR_W-1:0] wr_idx;
	logic [PTR_W:0]   tail_sum;
	logic [PTR_W-1:0] head_inc;
	logic [7:0]  rd;
	logic        txv;
	logic [7:0]  txb;
	logic        irq;
	logic        drop;
	logic        advance;
	logic        fifo_full;
	logic        fifo_empty;
	logic [3:0]  bits_new;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(res_q);

	assign fifo_full  = (rx_count_q == CNT_W'(RX_DEPTH));
	assign fifo_empty = (rx_count_q == '0);
	assign tail_sum   = {1'b0, head_q} + (PTR_W + 1)'(rx_count_q);
	assign wr_idx     = (tail_sum >= (PTR_W + 1)'(RX_DEPTH)) ?
	                    PTR_W'(tail_sum - (PTR_W + 1)'(RX_DEPTH)) : PTR_W'(tail_sum);
	assign head_inc   = (head_q == PTR_W'(RX_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign bits_new   = 4'd8 - {2'b00, data_s1[6:5]};

	always_comb begin
		command_d   = command_q;
		control_d   = control_q;
		parity_d    = parity_q;
		char_bits_d = char_bits_q;
		stop_d      = stop_q;
		rate_d      = rate_q;
		rts_d       = rts_q;
		dtr_d       = dtr_q;
		rx_flag_d   = rx_flag_q;
		tx_flag_d   = tx_flag_q;
		head_d      = head_q;
		rx_count_d  = rx_count_q;
		wr_en       = 1'b0;
		rd          = 8'h00;
		txv         = 1'b0;
		txb         = 8'h00;
		irq         = 1'b0;
		drop        = 1'b0;
		unique case (op_s1)
			OP_CMD_RD: begin
				rd = command_q;
			end
			OP_CMD_WR: begin
				command_d = data_s1;
				if ((data_s1 & CMD_PAR_EN) != 8'h00) begin
					parity_d = parity_t'({1'b0, data_s1[7:6]} + 3'd1);
				end else begin
					parity_d = PAR_NONE;
				end
				rts_d = (data_s1 & CMD_RTS) != 8'h00;
				dtr_d = (data_s1 & CMD_DTR) != 8'h00;
			end
			OP_CTL_RD: begin
				rd = control_q;
			end
			OP_CTL_WR: begin
				control_d   = data_s1;
				rate_d      = decode_rate(data_s1[3:0]);
				char_bits_d = bits_new;
				if ((data_s1 & CTL_STOP2) != 8'h00) begin
					if (bits_new == 4'd8 && parity_q != PAR_NONE) begin
						stop_d = STOP_ONE;
					end else if (bits_new == 4'd5 && parity_q == PAR_NONE) begin
						stop_d = STOP_ONE_HALF;
					end else begin
						stop_d = STOP_TWO;
					end
				end else begin
					stop_d = STOP_ONE;
				end
			end
			OP_STATUS: begin
				rd = ST_BASE
				   | (fifo_empty ? 8'h00 : ST_RX_FULL)
				   | (cd_s1 ? 8'h00 : ST_NO_DCD)
				   | (dsr_s1 ? 8'h00 : ST_NO_DSR)
				   | ((rx_flag_q || tx_flag_q) ? ST_IRQ : 8'h00);
				rx_flag_d = 1'b0;
				tx_flag_d = 1'b0;
			end
			OP_RX_RD: begin
				if (!fifo_empty) begin
					rd         = rx_fifo_q[head_q];
					head_d     = head_inc;
					rx_count_d = rx_count_q - 1'b1;
				end
			end
			OP_TX: begin
				txv = 1'b1;
				txb = data_s1;
				if ((command_q & CMD_RTS) == CMD_TX_IRQ) begin
					tx_flag_d = 1'b1;
					irq       = 1'b1;
				end
			end
			OP_LINE: begin
				if (!fifo_full) begin
					wr_en      = 1'b1;
					rx_count_d = rx_count_q + 1'b1;
				end else begin
					drop = 1'b1;
				end
			end
			OP_TICK: begin
				if (!fifo_empty) begin
					if ((command_q & CMD_DTR) != 8'h00) begin
						if ((command_q & CMD_RX_IRQD) == 8'h00) begin
							rx_flag_d = 1'b1;
							irq       = 1'b1;
						end
					end else begin
						rx_count_d = '0;
					end
				end else begin
					rx_flag_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= op_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata[7:0];
			cd_s1   <= s_axis_tdata[8];
			dsr_s1  <= s_axis_tdata[9];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.read_data   <= rd;
			res_q.tx_valid    <= txv;
			res_q.tx_byte     <= txb;
			res_q.baud_rate   <= rate_d;
			res_q.data_bits   <= char_bits_d;
			res_q.parity_mode <= parity_d;
			res_q.stop_bits   <= stop_d;
			res_q.rts_enable  <= rts_d;
			res_q.dtr_enable  <= dtr_d;
			res_q.irq_assert  <= irq;
			res_q.rx_dropped  <= drop;
		end
	end

	// register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q   <= CMD_RESET;
			control_q   <= CTL_RESET;
			parity_q    <= PAR_NONE;
			char_bits_q <= BITS_RESET;
			stop_q      <= STOP_ONE;
			rate_q      <= RATE_RESET;
			rts_q       <= 1'b0;
			dtr_q       <= 1'b0;
			rx_flag_q   <= 1'b0;
			tx_flag_q   <= 1'b0;
			head_q      <= '0;
			rx_count_q  <= '0;
		end else if (advance) begin
			command_q   <= command_d;
			control_q   <= control_d;
			parity_q    <= parity_d;
			char_bits_q <= char_bits_d;
			stop_q      <= stop_d;
			rate_q      <= rate_d;
			rts_q       <= rts_d;
			dtr_q       <= dtr_d;
			rx_flag_q   <= rx_flag_d;
			tx_flag_q   <= tx_flag_d;
			head_q      <= head_d;
			rx_count_q  <= rx_count_d;
		end
	end

	// receive buffer
	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			rx_fifo_q[wr_idx] <= data_s1;
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= CNT_W'(RX_DEPTH))
		else $error("receive count beyond buffer depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_q.rx_dropped) |-> fifo_full)
		else $error("byte dropped while buffer not full");

	a_tick_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_q.irq_assert && !res_q.tx_valid) |-> !fifo_empty)
		else $error("receive interrupt with empty buffer");

	a_tx_irq_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_TX && irq) |=> tx_flag_q)
		else $error("transmit interrupt without flag");
`endif

endmodule

[verif/acia_serial_register_model_checker.sv]
// ----------------------------------------------------------------------------
// acia serial register model, result checker
// follows every access into the block, keeps its own copy of the command,
// control, flag and receive buffer state, and compares each result transfer
// field by field with the outcome worked out for the oldest access still due
// ----------------------------------------------------------------------------
module acia_serial_register_model_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [acia_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // data_in, carrier_detect, data_set_ready
	input  logic [3:0]                     s_axis_tuser,  // opcode
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [acia_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // result_t, read_data lowest
	output int                             fail_count,
	output int                             results_checked,
	output int                             outcomes_waiting,
	output int                             drops_seen,
	output int                             irqs_seen
);
	import acia_pkg::*;

	logic [7:0]  cmd_q;
	logic [7:0]  ctl_q;
	parity_t     par_q;
	logic [3:0]  bits_q;
	stop_t       stop_q;
	logic [14:0] rate_q;
	logic        rts_q;
	logic        dtr_q;
	logic [7:0]  rx_buf [RX_DEPTH];
	int          rx_level;
	logic        rx_irq_q;
	logic        tx_irq_q;
	result_t     outcomes_due [$];

	function automatic logic [14:0] line_rate(input logic [3:0] code);
		if (code == 4'd15)
			return 15'd19200;
		else if (code >= 4'd13)
			return 15'd9600;
		else if (code >= 4'd11)
			return 15'd4800;
		else if (code >= 4'd9)
			return 15'd2400;
		else if (code == 4'd8)
			return 15'd1200;
		else if (code == 4'd7)
			return 15'd600;
		else if (code == 4'd6)
			return 15'd300;
		return 15'd110;
	endfunction

	task automatic step_serial_regs(input logic [3:0] op, input logic [7:0] d,
			input logic cd, input logic dsr, output result_t r);
		r = '0;
		case (op)
			OP_CMD_RD: r.read_data = cmd_q;
			OP_CMD_WR: begin
				cmd_q = d;
				par_q = (d & CMD_PAR_EN) ? parity_t'({1'b0, d[7:6]} + 3'd1) : PAR_NONE;
				rts_q = |(d & CMD_RTS);
				dtr_q = |(d & CMD_DTR);
			end
			OP_CTL_RD: r.read_data = ctl_q;
			OP_CTL_WR: begin
				ctl_q  = d;
				rate_q = line_rate(d[3:0]);
				bits_q = 4'd8 - {2'b00, d[6:5]};
				if (!(d & CTL_STOP2))
					stop_q = STOP_ONE;
				else if (bits_q == 4'd8 && par_q != PAR_NONE)
					stop_q = STOP_ONE;
				else if (bits_q == 4'd5 && par_q == PAR_NONE)
					stop_q = STOP_ONE_HALF;
				else
					stop_q = STOP_TWO;
			end
			OP_STATUS: begin
				r.read_data = ST_BASE
					| ((rx_level != 0) ? ST_RX_FULL : 8'h00)
					| (cd ? 8'h00 : ST_NO_DCD)
					| (dsr ? 8'h00 : ST_NO_DSR)
					| ((rx_irq_q || tx_irq_q) ? ST_IRQ : 8'h00);
				rx_irq_q = 1'b0;
				tx_irq_q = 1'b0;
			end
			OP_RX_RD: begin
				if (rx_level > 0) begin
					r.read_data = rx_buf[0];
					for (int i = 0; i < RX_DEPTH - 1; i++)
						rx_buf[i] = rx_buf[i + 1];
					rx_level--;
				end
			end
			OP_TX: begin
				r.tx_valid = 1'b1;
				r.tx_byte  = d;
				if ((cmd_q & CMD_RTS) == CMD_TX_IRQ) begin
					tx_irq_q     = 1'b1;
					r.irq_assert = 1'b1;
				end
			end
			OP_LINE: begin
				if (rx_level < RX_DEPTH) begin
					rx_buf[rx_level] = d;
					rx_level++;
				end else begin
					r.rx_dropped = 1'b1;
				end
			end
			OP_TICK: begin
				if (rx_level == 0) begin
					rx_irq_q = 1'b0;
				end else if (!(cmd_q & CMD_DTR)) begin
					rx_level = 0;
				end else if (!(cmd_q & CMD_RX_IRQD)) begin
					rx_irq_q     = 1'b1;
					r.irq_assert = 1'b1;
				end
			end
			default: ;
		endcase
		r.baud_rate   = rate_q;
		r.data_bits   = bits_q;
		r.parity_mode = par_q;
		r.stop_bits   = stop_q;
		r.rts_enable  = rts_q;
		r.dtr_enable  = dtr_q;
	endtask

	task automatic field_check(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			cmd_q    = CMD_RESET;
			ctl_q    = CTL_RESET;
			par_q    = PAR_NONE;
			bits_q   = BITS_RESET;
			stop_q   = STOP_ONE;
			rate_q   = RATE_RESET;
			rts_q    = 1'b0;
			dtr_q    = 1'b0;
			rx_level = 0;
			rx_irq_q = 1'b0;
			tx_irq_q = 1'b0;
			outcomes_due.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
				results_checked++;
				if (outcomes_due.size() == 0) begin
					$display("%0t: result transfer with nothing due, expected none, actual %h",
						$time, got);
					fail_count++;
				end else begin
					want = outcomes_due.pop_front();
					field_check("read_data", want.read_data, got.read_data);
					field_check("tx_valid", want.tx_valid, got.tx_valid);
					field_check("tx_byte", want.tx_byte, got.tx_byte);
					field_check("baud_rate", want.baud_rate, got.baud_rate);
					field_check("data_bits", want.data_bits, got.data_bits);
					field_check("parity_mode", want.parity_mode, got.parity_mode);
					field_check("stop_bits", want.stop_bits, got.stop_bits);
					field_check("rts_enable", want.rts_enable, got.rts_enable);
					field_check("dtr_enable", want.dtr_enable, got.dtr_enable);
					field_check("irq_assert", want.irq_assert, got.irq_assert);
					field_check("rx_dropped", want.rx_dropped, got.rx_dropped);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				step_serial_regs(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8],
					s_axis_tdata[9], want);
				outcomes_due.push_back(want);
				if (want.rx_dropped)
					drops_seen++;
				if (want.irq_assert)
					irqs_seen++;
			end
		end
		outcomes_waiting = outcomes_due.size();
	end

endmodule

[verif/acia_serial_register_model_top_test.sv]
// ----------------------------------------------------------------------------
// acia serial register model, regression bench
// drives register, status, transmit, line byte, tick and spare opcode accesses
// with random gaps on both channels, a long result hold-off to fill the pipeline,
// and a checker that predicts and compares every result transfer
// ----------------------------------------------------------------------------
module acia_serial_register_model_top_test;
	import acia_pkg::*;

	localparam logic [3:0] OP_SPARE_LO     = 4'd9;
	localparam logic [3:0] OP_SPARE_HI     = 4'd15;
	localparam int         RANDOM_ACCESSES = 520;
	localparam int         HOLD_CYCLES     = 80;
	localparam int         DRAIN_CYCLES    = 10;
	localparam int         CYCLE_LIMIT     = 300000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;  // data_in, carrier_detect, data_set_ready
	logic [3:0]            s_axis_tuser;  // opcode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;  // read_data up to rx_dropped

	int fail_count;
	int results_checked;
	int outcomes_waiting;
	int drops_seen;
	int irqs_seen;
	int cycles;
	int accesses_sent;
	int holds_done;
	bit hold_req;
	bit tx_calm;
	bit rx_calm;

	acia_serial_register_model_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	acia_serial_register_model_checker reg_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_axis_tvalid    (s_axis_tvalid),
		.s_axis_tready    (s_axis_tready),
		.s_axis_tdata     (s_axis_tdata),
		.s_axis_tuser     (s_axis_tuser),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.m_axis_tdata     (m_axis_tdata),
		.fail_count       (fail_count),
		.results_checked  (results_checked),
		.outcomes_waiting (outcomes_waiting),
		.drops_seen       (drops_seen),
		.irqs_seen        (irqs_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("acia_serial_register_model_top regression: fail");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	task automatic send_access(input logic [3:0] op, input logic [7:0] d,
			input logic cd, input logic dsr);
		int gap;
		logic [IN_DATA_W-1:0] word;
		gap = tx_calm ? 0 : idle_len();
		word = '0;
		word[7:0] = d;
		word[8] = cd;
		word[9] = dsr;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		accesses_sent++;
	endtask

	function automatic logic [3:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 24)
			return OP_LINE;
		else if (r < 36)
			return OP_RX_RD;
		else if (r < 46)
			return OP_TICK;
		else if (r < 56)
			return OP_STATUS;
		else if (r < 66)
			return OP_TX;
		else if (r < 74)
			return OP_CMD_WR;
		else if (r < 82)
			return OP_CTL_WR;
		else if (r < 88)
			return OP_CMD_RD;
		else if (r < 94)
			return OP_CTL_RD;
		return 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
	endfunction

	// receiving side: random stalls, calm stretches and one long hold-off
	initial begin
		int stall_left;
		int calm_timer;
		stall_left = 0;
		calm_timer = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			calm_timer++;
			if (calm_timer % 100 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 99) < 30)
					stall_left = idle_len();
			end
		end
	end

	initial begin
		int counted;
		int k;
		logic [3:0] op;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_CMD_RD;
		m_axis_tready = 1'b0;
		arst_n        = 1'b0;
		tx_calm       = 1'b0;
		rx_calm       = 1'b0;
		hold_req      = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values, empty buffer, missing modem lines
		send_access(OP_CMD_RD, 8'h00, 1'b1, 1'b1);
		send_access(OP_CTL_RD, 8'hFF, 1'b1, 1'b1);
		send_access(OP_STATUS, 8'h00, 1'b0, 1'b0);
		send_access(OP_RX_RD, 8'h00, 1'b1, 1'b1);
		send_access(OP_TICK, 8'h00, 1'b1, 1'b1);
		// parity with 8 and 5 data bits, one and a half stop bits, rate extremes
		send_access(OP_CMD_WR, 8'hFF, 1'b1, 1'b1);
		send_access(OP_CTL_WR, 8'h80, 1'b1, 1'b1);
		send_access(OP_CTL_WR, 8'hE0, 1'b1, 1'b1);
		send_access(OP_CMD_WR, 8'h05, 1'b1, 1'b1);
		send_access(OP_CTL_WR, 8'hFF, 1'b1, 1'b1);
		send_access(OP_CTL_WR, 8'h00, 1'b1, 1'b1);
		// transmit interrupt, then status clears it
		send_access(OP_TX, 8'hFF, 1'b1, 1'b1);
		send_access(OP_STATUS, 8'h00, 1'b1, 1'b1);
		// fill the buffer and overflow it
		for (int i = 0; i <= RX_DEPTH; i++)
			send_access(OP_LINE, (i % 2) ? 8'hFF : 8'(i), 1'b1, 1'b1);
		send_access(OP_TICK, 8'h00, 1'b1, 1'b1);
		send_access(OP_CMD_WR, 8'h03, 1'b1, 1'b1);
		send_access(OP_TICK, 8'h00, 1'b1, 1'b1);
		send_access(OP_RX_RD, 8'h00, 1'b1, 1'b1);
		send_access(OP_CMD_WR, 8'h00, 1'b1, 1'b1);
		send_access(OP_TICK, 8'h00, 1'b1, 1'b1);
		send_access(OP_RX_RD, 8'h00, 1'b1, 1'b1);
		send_access(OP_SPARE_LO, 8'hFF, 1'b1, 1'b1);
		send_access(OP_SPARE_HI, 8'h00, 1'b0, 1'b0);

		// long hold-off on the result side while accesses keep coming
		tx_calm  = 1'b1;
		hold_req = 1'b1;
		counted  = 0;
		k        = 0;
		while (counted < RANDOM_ACCESSES) begin
			k++;
			if (k % 40 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 8) begin
				repeat ($urandom_range(6, RX_DEPTH + 3)) begin
					send_access(OP_LINE, 8'($urandom), 1'($urandom), 1'($urandom));
					counted++;
				end
			end else begin
				op = pick_op();
				send_access(op, 8'($urandom), 1'($urandom), 1'($urandom));
				if (op < OP_SPARE_LO)
					counted++;
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (outcomes_waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d accesses in %0d cycles, %0d results compared, %0d long hold-off",
			accesses_sent, cycles, results_checked, holds_done);
		$display("line bytes dropped on a full buffer: %0d, accesses raising the interrupt: %0d",
			drops_seen, irqs_seen);
		if (fail_count == 0 && outcomes_waiting == 0) begin
			$display("acia_serial_register_model_top regression: pass");
		end else begin
			$display("acia_serial_register_model_top regression: fail");
		end
		$finish;
	end

endmodule
